FILE: design/scte_pkg.sv
// Shared types and constants for the smartcard T=0 procedure-byte engine.
// Used by scte_core and the top level smartcard_t0_procedure_engine.
package scte_pkg;

  localparam int unsigned RECV_CAPACITY = 4096;
  localparam int unsigned PosW = 13;

  localparam logic [7:0] ProcNull   = 8'h60;
  localparam logic [7:0] NibbleMask = 8'hF0;
  localparam logic [7:0] Sw1Hi6     = 8'h60;
  localparam logic [7:0] Sw1Hi9     = 8'h90;
  localparam logic [8:0] FullBlock  = 9'd256;

  localparam logic [15:0] ByteTimeoutReset = 16'd1000;
  localparam logic [15:0] DataTimeoutReset = 16'd5000;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PROC = 2'd1,
    PH_SW2  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_IO      = 2'd2,
    ST_SMALL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BYTE_TIMEOUT = 2'd0,
    REG_DATA_TIMEOUT = 2'd1
  } reg_idx_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] card_byte;
    logic [7:0] instr_code;
    logic [7:0] length_byte;
    logic [7:0] tx_count;
  } item_t;

  typedef struct packed {
    logic            store_valid;
    logic [7:0]      store_byte;
    logic [11:0]     store_index;
    logic            send_request;
    logic [7:0]      send_count;
    logic            done_res;
    status_t         status;
    logic [PosW-1:0] resp_length;
  } result_t;

endpackage

FILE: design/smartcard_t0_procedure_engine.sv
// Smartcard T=0 procedure-byte engine, host side: input register, scte_core, result register.
// An accepted item goes through the input register and scte_core into the result register.
// Throughput: one item per cycle unless a result waits; the input register and the result register
// decouple the two sides, so one more item is taken while a result waits for m_axis_tready.
// Reset (rst, synchronous): exchange idle, both registers empty, timeouts 1000 and 5000.
// Depends on scte_pkg and scte_core.
module smartcard_t0_procedure_engine
  import scte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // card_byte, instr_code, length_byte, tx_count
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // store_valid, store_byte, store_index, send_request, send_count, done_res,
  // status, resp_length, two zero bits
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        in_vld;
  item_t       in_item;
  logic        out_vld;
  result_t     out_res;
  logic [15:0] byte_timeout;
  logic [15:0] data_timeout;
  logic        step;
  logic        res_valid;
  result_t     res;

  assign step          = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || step;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_timeout <= ByteTimeoutReset;
      data_timeout <= DataTimeoutReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BYTE_TIMEOUT: byte_timeout <= cfg_data;
        REG_DATA_TIMEOUT: data_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.operation   <= op_t'(s_axis_tuser);
      in_item.card_byte   <= s_axis_tdata[7:0];
      in_item.instr_code  <= s_axis_tdata[15:8];
      in_item.length_byte <= s_axis_tdata[23:16];
      in_item.tx_count    <= s_axis_tdata[31:24];
    end
  end

  scte_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (in_item),
    .byte_timeout (byte_timeout),
    .data_timeout (data_timeout),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (res_valid) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {2'b00, out_res.resp_length, out_res.status, out_res.done_res,
                          out_res.send_count, out_res.send_request, out_res.store_index,
                          out_res.store_byte, out_res.store_valid};

endmodule

FILE: design/scte_core.sv
// Procedure-byte state and per-item next-state logic of the T=0 engine.
// Depends on scte_pkg for item, result, phase and status types.
module scte_core
  import scte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  item_t       item,
  input  logic [15:0] byte_timeout,
  input  logic [15:0] data_timeout,
  output logic        res_valid,
  output result_t     res
);

  phase_t          phase, phase_next;
  logic            data_sent, data_sent_next;
  logic [7:0]      saved_instr, saved_instr_next;
  logic [7:0]      saved_p3, saved_p3_next;
  logic [7:0]      saved_tx_count, saved_tx_count_next;
  logic [PosW-1:0] write_pos, write_pos_next;
  logic [PosW-1:0] phase_start_pos, phase_start_pos_next;
  logic [8:0]      bytes_remaining, bytes_remaining_next;
  logic [15:0]     elapsed_ticks, elapsed_ticks_next;

  logic [PosW:0]   pos_plus2;
  logic [PosW:0]   pos_plus_cnt;
  logic [8:0]      cnt;
  logic [16:0]     tick_next;
  logic [15:0]     limit;
  logic [PosW-1:0] pos_plus1;
  logic [8:0]      rem_dec;
  logic            is_sw1;

  assign pos_plus2    = {1'b0, write_pos} + (PosW+1)'(2);
  assign cnt          = (saved_p3 != 8'd0) ? {1'b0, saved_p3} : FullBlock;
  assign pos_plus_cnt = pos_plus2 + (PosW+1)'(cnt);
  assign pos_plus1    = write_pos + PosW'(1);
  assign tick_next    = {1'b0, elapsed_ticks} + 17'd1;
  assign limit        = (phase == PH_DATA) ? data_timeout : byte_timeout;
  assign rem_dec      = (bytes_remaining != 9'd0) ? bytes_remaining - 9'd1 : 9'd0;
  assign is_sw1       = ((item.card_byte & NibbleMask) == Sw1Hi6) ||
                        ((item.card_byte & NibbleMask) == Sw1Hi9);

  always_comb begin
    phase_next           = phase;
    data_sent_next       = data_sent;
    saved_instr_next     = saved_instr;
    saved_p3_next        = saved_p3;
    saved_tx_count_next  = saved_tx_count;
    write_pos_next       = write_pos;
    phase_start_pos_next = phase_start_pos;
    bytes_remaining_next = bytes_remaining;
    elapsed_ticks_next   = elapsed_ticks;
    res_valid            = 1'b0;
    res                  = '0;
    case (item.operation)
      OP_START: begin
        saved_instr_next     = item.instr_code;
        saved_p3_next        = item.length_byte;
        saved_tx_count_next  = item.tx_count;
        data_sent_next       = 1'b0;
        write_pos_next       = '0;
        phase_start_pos_next = '0;
        bytes_remaining_next = '0;
        elapsed_ticks_next   = '0;
        phase_next           = PH_PROC;
      end
      OP_BYTE: begin
        case (phase)
          PH_PROC: begin
            elapsed_ticks_next = '0;
            if (item.card_byte == ProcNull) begin
              // keep waiting
            end else if (is_sw1) begin
              res_valid = 1'b1;
              if (pos_plus2 > (PosW+1)'(RECV_CAPACITY)) begin
                phase_next      = PH_IDLE;
                res.done_res    = 1'b1;
                res.status      = ST_SMALL;
                res.resp_length = write_pos;
              end else begin
                phase_next      = PH_SW2;
                res.store_valid = 1'b1;
                res.store_byte  = item.card_byte;
                res.store_index = write_pos[11:0];
              end
            end else if (item.card_byte == saved_instr) begin
              if (data_sent) begin
                res_valid       = 1'b1;
                phase_next      = PH_IDLE;
                res.done_res    = 1'b1;
                res.status      = ST_IO;
                res.resp_length = write_pos;
              end else begin
                data_sent_next = 1'b1;
                if (saved_tx_count != 8'd0) begin
                  res_valid        = 1'b1;
                  res.send_request = 1'b1;
                  res.send_count   = saved_tx_count;
                end else if (pos_plus_cnt > (PosW+1)'(RECV_CAPACITY)) begin
                  res_valid       = 1'b1;
                  phase_next      = PH_IDLE;
                  res.done_res    = 1'b1;
                  res.status      = ST_SMALL;
                  res.resp_length = write_pos;
                end else begin
                  bytes_remaining_next = cnt;
                  phase_start_pos_next = write_pos;
                  phase_next           = PH_DATA;
                end
              end
            end else begin
              res_valid       = 1'b1;
              phase_next      = PH_IDLE;
              res.done_res    = 1'b1;
              res.status      = ST_IO;
              res.resp_length = write_pos;
            end
          end
          PH_SW2: begin
            res_valid       = 1'b1;
            write_pos_next  = pos_plus2[PosW-1:0];
            phase_next      = PH_IDLE;
            res.store_valid = 1'b1;
            res.store_byte  = item.card_byte;
            res.store_index = pos_plus1[11:0];
            res.done_res    = 1'b1;
            res.status      = ST_OK;
            res.resp_length = pos_plus2[PosW-1:0];
          end
          PH_DATA: begin
            res_valid            = 1'b1;
            write_pos_next       = pos_plus1;
            bytes_remaining_next = rem_dec;
            if (rem_dec == 9'd0) begin
              phase_next         = PH_PROC;
              elapsed_ticks_next = '0;
            end
            res.store_valid = 1'b1;
            res.store_byte  = item.card_byte;
            res.store_index = write_pos[11:0];
          end
          default: begin
          end
        endcase
      end
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (tick_next >= {1'b0, limit}) begin
            res_valid       = 1'b1;
            phase_next      = PH_IDLE;
            res.done_res    = 1'b1;
            res.status      = ST_TIMEOUT;
            // a timed-out data phase drops its partial data
            res.resp_length = (phase == PH_DATA) ? phase_start_pos : write_pos;
          end else begin
            elapsed_ticks_next = tick_next[15:0];
          end
        end
      end
      default: begin
      end
    endcase
    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      data_sent       <= 1'b0;
      saved_instr     <= '0;
      saved_p3        <= '0;
      saved_tx_count  <= '0;
      write_pos       <= '0;
      phase_start_pos <= '0;
      bytes_remaining <= '0;
      elapsed_ticks   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      data_sent       <= data_sent_next;
      saved_instr     <= saved_instr_next;
      saved_p3        <= saved_p3_next;
      saved_tx_count  <= saved_tx_count_next;
      write_pos       <= write_pos_next;
      phase_start_pos <= phase_start_pos_next;
      bytes_remaining <= bytes_remaining_next;
      elapsed_ticks   <= elapsed_ticks_next;
    end
  end

endmodule

FILE: dv/smartcard_t0_procedure_engine_checker.sv
// Checker for the smartcard T=0 procedure-byte engine: watches the config, input and
// result channels, predicts each exchange step and compares the results in order.
// Depends on scte_pkg.
module smartcard_t0_procedure_engine_checker
  import scte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t      xfer_phase;
  logic        echo_seen;
  logic [7:0]  cmd_ins;
  logic [7:0]  cmd_p3;
  logic [7:0]  cmd_tx;
  logic [12:0] wr_pos;
  logic [12:0] data_base;
  logic [8:0]  data_left;
  logic [15:0] tick_count;
  logic [15:0] byte_limit;
  logic [15:0] data_limit;
  result_t     awaited_results[$];
  int          fail_total = 0;
  int          result_num = 0;

  assign mismatches = fail_total;

  task automatic end_exchange(input status_t st, input logic [12:0] len);
    result_t r;
    r = '0;
    r.done_res    = 1'b1;
    r.status      = st;
    r.resp_length = len;
    xfer_phase = PH_IDLE;
    awaited_results.push_back(r);
  endtask

  task automatic store_result(input logic [7:0] b, input logic [12:0] pos);
    result_t r;
    r = '0;
    r.store_valid = 1'b1;
    r.store_byte  = b;
    r.store_index = pos[11:0];
    awaited_results.push_back(r);
  endtask

  task automatic card_byte_step(input logic [7:0] b);
    result_t r;
    int unsigned cnt;
    case (xfer_phase)
      PH_PROC: begin
        tick_count = '0;
        if (b == ProcNull) begin
          // keep waiting
        end else if ((b & NibbleMask) == Sw1Hi6 || (b & NibbleMask) == Sw1Hi9) begin
          if (int'(wr_pos) + 2 > RECV_CAPACITY) begin
            end_exchange(ST_SMALL, wr_pos);
          end else begin
            xfer_phase = PH_SW2;
            store_result(b, wr_pos);
          end
        end else if (b == cmd_ins) begin
          if (echo_seen) begin
            end_exchange(ST_IO, wr_pos);
          end else begin
            echo_seen = 1'b1;
            if (cmd_tx != 8'd0) begin
              r = '0;
              r.send_request = 1'b1;
              r.send_count   = cmd_tx;
              awaited_results.push_back(r);
            end else begin
              cnt = (cmd_p3 != 8'd0) ? cmd_p3 : FullBlock;
              if (int'(wr_pos) + cnt + 2 > RECV_CAPACITY) begin
                end_exchange(ST_SMALL, wr_pos);
              end else begin
                data_left  = 9'(cnt);
                data_base  = wr_pos;
                xfer_phase = PH_DATA;
              end
            end
          end
        end else begin
          end_exchange(ST_IO, wr_pos);
        end
      end
      PH_SW2: begin
        r = '0;
        r.store_valid = 1'b1;
        r.store_byte  = b;
        r.store_index = wr_pos[11:0] + 12'd1;
        wr_pos = wr_pos + 13'd2;
        r.done_res    = 1'b1;
        r.status      = ST_OK;
        r.resp_length = wr_pos;
        xfer_phase = PH_IDLE;
        awaited_results.push_back(r);
      end
      PH_DATA: begin
        store_result(b, wr_pos);
        wr_pos = wr_pos + 13'd1;
        if (data_left != 9'd0) data_left = data_left - 9'd1;
        if (data_left == 9'd0) begin
          xfer_phase = PH_PROC;
          tick_count = '0;
        end
      end
      default: begin
        // idle: card bytes are dropped
      end
    endcase
  endtask

  task automatic tick_step();
    logic [16:0] nxt;
    logic [15:0] lim;
    if (xfer_phase != PH_IDLE) begin
      nxt = {1'b0, tick_count} + 17'd1;
      lim = (xfer_phase == PH_DATA) ? data_limit : byte_limit;
      if (nxt >= {1'b0, lim}) begin
        // data-phase timeout drops the partial data from the length
        end_exchange(ST_TIMEOUT, (xfer_phase == PH_DATA) ? data_base : wr_pos);
      end else begin
        tick_count = nxt[15:0];
      end
    end
  endtask

  task automatic exchange_step(input op_t op, input logic [31:0] d);
    case (op)
      OP_START: begin
        cmd_ins    = d[15:8];
        cmd_p3     = d[23:16];
        cmd_tx     = d[31:24];
        echo_seen  = 1'b0;
        wr_pos     = '0;
        data_base  = '0;
        data_left  = '0;
        tick_count = '0;
        xfer_phase = PH_PROC;
      end
      OP_BYTE: card_byte_step(d[7:0]);
      OP_TICK: tick_step();
      default: begin
      end
    endcase
  endtask

  task automatic compare_result(input logic [47:0] raw);
    result_t got;
    result_t want;
    logic    bad;
    got.store_valid  = raw[0];
    got.store_byte   = raw[8:1];
    got.store_index  = raw[20:9];
    got.send_request = raw[21];
    got.send_count   = raw[29:22];
    got.done_res     = raw[30];
    got.status       = status_t'(raw[32:31]);
    got.resp_length  = raw[45:33];
    result_num++;
    if (awaited_results.size() == 0) begin
      fail_total++;
      if (fail_total <= 10)
        $display("result %0d arrived with nothing expected: %h", result_num, raw);
    end else begin
      want = awaited_results.pop_front();
      bad = (got.store_valid  !== want.store_valid)  ||
            (got.store_byte   !== want.store_byte)   ||
            (got.store_index  !== want.store_index)  ||
            (got.send_request !== want.send_request) ||
            (got.send_count   !== want.send_count)   ||
            (got.done_res     !== want.done_res)     ||
            (got.status       !== want.status)       ||
            (got.resp_length  !== want.resp_length)  ||
            (raw[47:46] !== 2'b00);
      if (bad) begin
        fail_total++;
        if (fail_total <= 10) begin
          $display("result %0d mismatch", result_num);
          $display("  expected sv=%0d byte=%h idx=%0d req=%0d cnt=%0d done=%0d st=%0d len=%0d",
                   want.store_valid, want.store_byte, want.store_index, want.send_request,
                   want.send_count, want.done_res, want.status, want.resp_length);
          $display("  actual   sv=%0d byte=%h idx=%0d req=%0d cnt=%0d done=%0d st=%0d len=%0d",
                   got.store_valid, got.store_byte, got.store_index, got.send_request,
                   got.send_count, got.done_res, got.status, got.resp_length);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      xfer_phase = PH_IDLE;
      echo_seen  = 1'b0;
      cmd_ins    = '0;
      cmd_p3     = '0;
      cmd_tx     = '0;
      wr_pos     = '0;
      data_base  = '0;
      data_left  = '0;
      tick_count = '0;
      byte_limit = ByteTimeoutReset;
      data_limit = DataTimeoutReset;
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BYTE_TIMEOUT: byte_limit = cfg_data;
          REG_DATA_TIMEOUT: data_limit = cfg_data;
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) exchange_step(op_t'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata);
      outstanding <= awaited_results.size();
    end
  end

endmodule

FILE: dv/smartcard_t0_procedure_engine_test.sv
// Top of the smartcard T=0 procedure-byte engine test: clock, reset, directed and random
// exchanges, config phases, random idling and a long result hold-off.
// Depends on scte_pkg, smartcard_t0_procedure_engine and its checker.
module smartcard_t0_procedure_engine_test;
  import scte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_SET [8] = '{4, 1, 65535, 2, 9, 0, 3, 65535};
  localparam int DATA_SET [8] = '{40, 1, 65535, 300, 6, 0, 65535, 2};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int   mismatches;
  int   outstanding;
  int   sent = 0;
  int   byte_lim = int'(ByteTimeoutReset);
  int   data_lim = int'(DataTimeoutReset);
  logic calm = 1'b0;
  logic hold_now = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  smartcard_t0_procedure_engine dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  smartcard_t0_procedure_engine_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  task automatic put(input op_t op, input logic [7:0] cb, input logic [7:0] ins,
                     input logic [7:0] p3, input logic [7:0] tx);
    if (!calm) begin
      while ($urandom_range(99) < 23) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tx, p3, ins, cb};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic card(input logic [7:0] b);
    put(OP_BYTE, b, 8'($urandom_range(255)), 8'($urandom_range(255)),
        8'($urandom_range(255)));
  endtask

  task automatic ticks(input int n);
    repeat (n) put(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic start(input logic [7:0] ins, input logic [7:0] p3, input logic [7:0] tx);
    put(OP_START, 8'($urandom_range(255)), ins, p3, tx);
  endtask

  // drop valid, let every expected result drain and the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int v);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_BYTE_TIMEOUT) byte_lim = v;
    else data_lim = v;
  endtask

  function automatic int quiet_ticks(input int lim);
    return (lim > 3) ? $urandom_range(2) : 0;
  endfunction

  function automatic logic [7:0] status_byte();
    logic [7:0] b;
    b = {($urandom_range(1) != 0) ? 4'h6 : 4'h9, 4'($urandom_range(15))};
    if (b == ProcNull) b = 8'h61;
    return b;
  endfunction

  // one exchange, mostly well formed with random content; about one in six is broken
  task automatic run_exchange();
    logic [7:0]  ins;
    logic [7:0]  p3;
    logic [7:0]  tx;
    int unsigned mode;
    int unsigned r;
    int          cnt;
    ins = 8'($urandom_range(255));
    if ($urandom_range(9) != 0)
      while (ins == ProcNull || ins[7:4] == 4'h6 || ins[7:4] == 4'h9)
        ins = 8'($urandom_range(255));
    r  = $urandom_range(99);
    p3 = (r < 5) ? 8'd0 : (r < 12) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 10));
    tx = ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom_range(255));
    mode = $urandom_range(99);
    start(ins, p3, tx);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(1) != 0) card(ProcNull);
      else ticks(quiet_ticks(byte_lim));
    end
    if (mode < 5) begin
      repeat ($urandom_range(1, 4)) card(8'($urandom_range(255)));
      return;
    end
    if (mode < 8) begin
      // restart while busy
      start(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      return;
    end
    card(ins);
    if (tx != 8'd0) begin
      ticks(quiet_ticks(byte_lim));
      if (mode < 11) begin
        card(ins);
        return;
      end
    end else begin
      cnt = (p3 != 8'd0) ? p3 : 256;
      repeat (cnt) begin
        card(8'($urandom_range(255)));
        if ($urandom_range(7) == 0) ticks(1);
      end
      if (mode < 11 && data_lim <= 64) begin
        ticks(data_lim);
        return;
      end
    end
    if ($urandom_range(3) == 0) card(ProcNull);
    if (mode < 12 && byte_lim <= 64) begin
      ticks(byte_lim);
      return;
    end
    card(status_byte());
    if (mode < 14 && byte_lim <= 64) begin
      ticks(byte_lim);
      return;
    end
    ticks(quiet_ticks(byte_lim));
    card(8'($urandom_range(255)));
    if (mode < 20) begin
      put(OP_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
          8'($urandom_range(255)), 8'($urandom_range(255)));
      card(8'($urandom_range(255)));
      ticks(1);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (500) @(posedge clk);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("smartcard_t0_procedure_engine_test: FAIL");
    $finish;
  end

  initial begin
    int p;
    int target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_BYTE_TIMEOUT, 3);
    write_reg(REG_DATA_TIMEOUT, 4);
    // read of two data bytes at both extremes, NULL before the echo, then status
    start(8'hA4, 8'd2, 8'd0);
    card(ProcNull);
    card(8'hA4);
    card(8'h00);
    card(8'hFF);
    card(8'h90);
    card(8'h00);
    // idle: no results
    card(8'h12);
    ticks(1);
    put(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // outgoing data request, then repeated echo
    start(8'hD6, 8'h10, 8'hFF);
    card(8'hD6);
    card(8'hD6);
    // INS in the status-byte class, then SW2 timeout
    start(8'h6C, 8'd1, 8'd1);
    card(8'h6C);
    ticks(3);
    // NULL value as raw data, then data-phase timeout
    start(8'hB0, 8'd3, 8'd0);
    card(8'hB0);
    card(ProcNull);
    ticks(4);
    // unknown procedure byte
    start(8'h20, 8'd0, 8'd0);
    card(8'h55);
    // timeout register of zero behaves as one
    write_reg(REG_BYTE_TIMEOUT, 0);
    start(8'h30, 8'd5, 8'd0);
    ticks(1);

    for (p = 0; p < 8; p++) begin
      write_reg(REG_BYTE_TIMEOUT, (p == 5) ? $urandom_range(1, 20) : BYTE_SET[p]);
      write_reg(REG_DATA_TIMEOUT, (p == 5) ? $urandom_range(1, 50) : DATA_SET[p]);
      calm = (p == 4);
      if (p == 2) hold_now = 1'b1;
      // long exchanges overshoot the target, so aim below 200 per phase
      target = sent + 130;
      while (sent < target) run_exchange();
    end
    calm = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("smartcard_t0_procedure_engine_test: PASS");
    end else begin
      $display("smartcard_t0_procedure_engine_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: smartcard_t0_procedure_engine.f
design/scte_pkg.sv
design/scte_core.sv
design/smartcard_t0_procedure_engine.sv
dv/smartcard_t0_procedure_engine_checker.sv
dv/smartcard_t0_procedure_engine_test.sv
